FILE: rtl/led_color_gradient_pixel_unit_assert.svh
// Assertion macros for the gradient pixel unit.
// LCG_ASSERT_IMPL checks a consequence in the same cycle, LCG_ASSERT_NEXT in the cycle after.
`ifndef LED_COLOR_GRADIENT_PIXEL_UNIT_ASSERT_SVH
`define LED_COLOR_GRADIENT_PIXEL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LCG_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("gradient unit check failed");
`define LCG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("gradient unit check failed");
`else
`define LCG_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define LCG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

FILE: rtl/lcg_pkg.sv
`timescale 1ns / 1ps
package lcg_pkg;

    // field widths
    localparam int LEN_W   = 13;
    localparam int KEYS_W  = 4;
    localparam int IDX_W   = 12;
    localparam int CH_W    = 8;
    localparam int RGB_W   = 3 * CH_W;
    localparam int STAT_W  = 2;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 13;

    // shared divider: dividend is sized for offset times channel delta
    localparam int DIV_W     = LEN_W + CH_W;
    localparam int DVS_W     = LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int MUL_CNT_W = $clog2(CH_W + 1);

    // register indexes
    localparam logic [CFG_AW-1:0] REG_STRIP = 2'd0;
    localparam logic [CFG_AW-1:0] REG_KEYS  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_WHEEL = 2'd2;

    // register reset values
    localparam logic [LEN_W-1:0]  STRIP_RST = 13'd64;
    localparam logic [KEYS_W-1:0] KEYS_RST  = 4'd2;
    localparam logic              WHEEL_RST = 1'b0;

    // operations
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_WIDTH = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SLOT  = 2'd3;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } lcg_chan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WDIV,
        S_SSTART,
        S_SDIV,
        S_RD_SEG,
        S_RD_NXT,
        S_RD_DONE,
        S_MSETUP,
        S_MUL,
        S_CSTART,
        S_CDIV,
        S_DONE
    } lcg_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } lcg_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } lcg_div_rsp_t;

endpackage

FILE: rtl/lcg_in_if.sv
`timescale 1ns / 1ps
interface lcg_in_if;
    import lcg_pkg::*;

    logic             valid;
    logic             ready;
    logic             operation;
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    modport source (
        output valid, operation, index, red, green, blue,
        input  ready
    );

    modport sink (
        input  valid, operation, index, red, green, blue,
        output ready
    );
endinterface

FILE: rtl/lcg_out_if.sv
`timescale 1ns / 1ps
interface lcg_out_if;
    import lcg_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;
    logic [STAT_W-1:0] status;

    modport source (
        output valid, out_red, out_green, out_blue, status,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, status,
        output ready
    );
endinterface

FILE: rtl/led_color_gradient_pixel_unit.sv
// Gradient pixel unit: holds a table of MAX_KEYS RGB key colors (all black after reset)
// and renders one strip position per request as a piecewise-linear blend between keys,
// open line or closed wheel, with truncating signed interpolation. A key write, and a
// render rejected for position or for having no segment, goes from idle to the done
// state and from there into the output register. A full render uses one shared
// bit-serial divider for the segment width, the position split and one quotient per
// channel, plus a shift-add multiply per channel. One request is worked on at a time;
// the next is taken while the previous result waits in the output register.
// Configuration registers must be written only while the unit is idle.
`timescale 1ns / 1ps
`include "led_color_gradient_pixel_unit_assert.svh"
module led_color_gradient_pixel_unit #(
    parameter int MAX_KEYS   = 8,
    parameter int MAX_PIXELS = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [lcg_pkg::CFG_AW-1:0] cfg_index,
    input  logic [lcg_pkg::CFG_DW-1:0] cfg_data,
    lcg_in_if.sink                     pixel_in,
    lcg_out_if.source                  pixel_out
);
    import lcg_pkg::*;

    localparam int KEY_AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    // configuration
    logic [LEN_W-1:0]  strip_length_reg, strip_length_next;
    logic [KEYS_W-1:0] key_count_reg, key_count_next;
    logic              wheel_mode_reg, wheel_mode_next;

    // control
    lcg_state_t           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MAX_KEYS-1:0]  key_valid_reg, key_valid_next;
    lcg_chan_t            chan_reg, chan_next;
    logic [MUL_CNT_W-1:0] mcnt_reg, mcnt_next;

    // payload
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [LEN_W-1:0]  width_reg, width_next;
    logic [KEYS_W-1:0] seg_reg, seg_next;
    logic [LEN_W-1:0]  off_reg, off_next;
    logic [RGB_W-1:0]  c1_reg, c1_next;
    logic [RGB_W-1:0]  c2_reg, c2_next;
    logic              neg_reg, neg_next;
    logic [CH_W-1:0]   mplier_reg, mplier_next;
    logic [DIV_W-1:0]  prod_reg, prod_next;
    logic [CH_W-1:0]   res_red_reg, res_red_next;
    logic [CH_W-1:0]   res_green_reg, res_green_next;
    logic [CH_W-1:0]   res_blue_reg, res_blue_next;
    logic [CH_W-1:0]   out_red_reg, out_green_reg, out_blue_reg;
    logic [STAT_W-1:0] out_status_reg;

    // key table
    logic [RGB_W-1:0]  key_mem [MAX_KEYS];
    logic [RGB_W-1:0]  rd_mem_reg;
    logic              rd_valid_reg;
    logic [RGB_W-1:0]  rd_data;
    logic [KEY_AW-1:0] rd_addr;
    logic [KEY_AW-1:0] wr_addr;
    logic              mem_we;

    // derived
    logic              in_acc;
    logic              out_free;
    logic              out_load;
    logic [LEN_W-1:0]  len_eff;
    logic [KEYS_W-1:0] keys_eff;
    logic [KEYS_W-1:0] segs;
    logic              range_err;
    logic              slot_err;
    logic [KEYS_W:0]   nxt_inc;
    logic [KEYS_W-1:0] nxt_idx;
    logic [CH_W-1:0]   ch_a, ch_b, ch_val;
    logic [CH_W-1:0]   q8;

    lcg_div_req_t div_req;
    lcg_div_rsp_t div_rsp;

    function automatic logic [CH_W-1:0] chan_pick(input logic [RGB_W-1:0] rgb,
                                                  input lcg_chan_t ch);
        logic [CH_W-1:0] v;
        unique case (ch)
            CH_RED:   v = rgb[3*CH_W-1:2*CH_W];
            CH_GREEN: v = rgb[2*CH_W-1:CH_W];
            CH_BLUE:  v = rgb[CH_W-1:0];
            default:  v = '0;
        endcase
        return v;
    endfunction

    lcg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // clamp registers to the built table and strip size
    always_comb
    begin
        len_eff  = (32'(strip_length_reg) > 32'(MAX_PIXELS)) ? LEN_W'(MAX_PIXELS)
                                                             : strip_length_reg;
        keys_eff = (32'(key_count_reg) > 32'(MAX_KEYS)) ? KEYS_W'(MAX_KEYS) : key_count_reg;
        if (wheel_mode_reg)
            segs = keys_eff;
        else
            segs = (keys_eff == '0) ? '0 : keys_eff - 1'b1;
    end

    assign in_acc    = pixel_in.valid & pixel_in.ready;
    assign out_free  = !out_valid_reg | pixel_out.ready;
    assign range_err = ({1'b0, pixel_in.index} >= len_eff);
    assign slot_err  = (32'(pixel_in.index) >= 32'(MAX_KEYS));
    assign wr_addr   = KEY_AW'(pixel_in.index);

    // next key wraps to slot 0
    assign nxt_inc = {1'b0, seg_reg} + 1'b1;
    assign nxt_idx = (nxt_inc >= {1'b0, keys_eff}) ? '0 : nxt_inc[KEYS_W-1:0];

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

    // channel blend: c1 plus or minus the truncated quotient
    assign ch_a   = chan_pick(c1_reg, chan_reg);
    assign ch_b   = chan_pick(c2_reg, chan_reg);
    assign q8     = div_rsp.quotient[CH_W-1:0];
    assign ch_val = neg_reg ? (ch_a - q8) : (ch_a + q8);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (pixel_in.operation == OP_WRITE || range_err || segs == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (div_rsp.done)
                    state_next = (div_rsp.quotient == '0) ? S_DONE : S_SSTART;
            end
            S_SSTART:  state_next = S_SDIV;
            S_SDIV:
            begin
                if (div_rsp.done)
                    state_next = S_RD_SEG;
            end
            S_RD_SEG:  state_next = S_RD_NXT;
            S_RD_NXT:  state_next = S_RD_DONE;
            S_RD_DONE: state_next = S_MSETUP;
            S_MSETUP:  state_next = S_MUL;
            S_MUL:
            begin
                if (mcnt_reg == MUL_CNT_W'(1))
                    state_next = S_CSTART;
            end
            S_CSTART:  state_next = S_CDIV;
            S_CDIV:
            begin
                if (div_rsp.done)
                    state_next = (chan_reg == CH_BLUE) ? S_DONE : S_MSETUP;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pixel_in.ready   = (state_reg == S_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        mem_we           = 1'b0;
        rd_addr          = '0;
        out_load         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && pixel_in.operation == OP_RENDER && !range_err && segs != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(len_eff);
                    div_req.divisor  = DVS_W'(segs);
                end
                mem_we = in_acc && (pixel_in.operation == OP_WRITE) && !slot_err;
            end
            S_SSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(idx_reg);
                div_req.divisor  = width_reg;
            end
            S_RD_SEG: rd_addr = KEY_AW'(seg_reg);
            S_RD_NXT: rd_addr = KEY_AW'(nxt_idx);
            S_CSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = width_reg;
            end
            S_DONE:   out_load = out_free;
            default:  ;
        endcase
    end

    // configuration writes, valid bits, output handshake, counters
    always_comb
    begin
        strip_length_next = strip_length_reg;
        key_count_next    = key_count_reg;
        wheel_mode_next   = wheel_mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STRIP: strip_length_next = cfg_data[LEN_W-1:0];
                REG_KEYS:  key_count_next    = cfg_data[KEYS_W-1:0];
                REG_WHEEL: wheel_mode_next   = cfg_data[0];
                default:   ;
            endcase
        end

        key_valid_next = key_valid_reg;
        if (mem_we)
            key_valid_next[wr_addr] = 1'b1;

        if (out_load)
            out_valid_next = 1'b1;
        else if (pixel_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        chan_next = chan_reg;
        if (state_reg == S_RD_DONE)
            chan_next = CH_RED;
        else if (state_reg == S_CDIV && div_rsp.done && chan_reg != CH_BLUE)
            chan_next = (chan_reg == CH_RED) ? CH_GREEN : CH_BLUE;

        mcnt_next = mcnt_reg;
        if (state_reg == S_MSETUP)
            mcnt_next = MUL_CNT_W'(CH_W);
        else if (state_reg == S_MUL)
            mcnt_next = mcnt_reg - 1'b1;
    end

    // datapath
    always_comb
    begin
        idx_next       = idx_reg;
        status_next    = status_reg;
        width_next     = width_reg;
        seg_next       = seg_reg;
        off_next       = off_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        neg_next       = neg_reg;
        mplier_next    = mplier_reg;
        prod_next      = prod_reg;
        res_red_next   = res_red_reg;
        res_green_next = res_green_reg;
        res_blue_next  = res_blue_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    idx_next       = pixel_in.index;
                    res_red_next   = '0;
                    res_green_next = '0;
                    res_blue_next  = '0;
                    if (pixel_in.operation == OP_WRITE)
                        status_next = slot_err ? STAT_SLOT : STAT_OK;
                    else if (range_err)
                        status_next = STAT_RANGE;
                    else if (segs == '0)
                        status_next = STAT_WIDTH;
                    else
                        status_next = STAT_OK;
                end
            end
            S_WDIV:
            begin
                if (div_rsp.done)
                begin
                    width_next = div_rsp.quotient[LEN_W-1:0];
                    if (div_rsp.quotient == '0)
                        status_next = STAT_WIDTH;
                end
            end
            S_SDIV:
            begin
                // past the last full segment: hold the last computed pixel
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient >= DIV_W'(segs))
                    begin
                        seg_next = segs - 1'b1;
                        off_next = width_reg - 1'b1;
                    end
                    else
                    begin
                        seg_next = div_rsp.quotient[KEYS_W-1:0];
                        off_next = div_rsp.remainder;
                    end
                end
            end
            S_RD_NXT:  c1_next = rd_data;
            S_RD_DONE: c2_next = rd_data;
            S_MSETUP:
            begin
                neg_next    = (ch_b < ch_a);
                mplier_next = (ch_b < ch_a) ? (ch_a - ch_b) : (ch_b - ch_a);
                prod_next   = '0;
            end
            S_MUL:
            begin
                // MSB-first shift-add of offset times delta magnitude
                prod_next   = {prod_reg[DIV_W-2:0], 1'b0}
                            + (mplier_reg[CH_W-1] ? DIV_W'(off_reg) : DIV_W'(0));
                mplier_next = {mplier_reg[CH_W-2:0], 1'b0};
            end
            S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    unique case (chan_reg)
                        CH_RED:   res_red_next   = ch_val;
                        CH_GREEN: res_green_next = ch_val;
                        CH_BLUE:  res_blue_next  = ch_val;
                        default:  ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= STRIP_RST;
            key_count_reg    <= KEYS_RST;
            wheel_mode_reg   <= WHEEL_RST;
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            key_valid_reg    <= '0;
            chan_reg         <= CH_RED;
            mcnt_reg         <= '0;
        end
        else
        begin
            strip_length_reg <= strip_length_next;
            key_count_reg    <= key_count_next;
            wheel_mode_reg   <= wheel_mode_next;
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            key_valid_reg    <= key_valid_next;
            chan_reg         <= chan_next;
            mcnt_reg         <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        status_reg    <= status_next;
        width_reg     <= width_next;
        seg_reg       <= seg_next;
        off_reg       <= off_next;
        c1_reg        <= c1_next;
        c2_reg        <= c2_next;
        neg_reg       <= neg_next;
        mplier_reg    <= mplier_next;
        prod_reg      <= prod_next;
        res_red_reg   <= res_red_next;
        res_green_reg <= res_green_next;
        res_blue_reg  <= res_blue_next;
        if (out_load)
        begin
            out_red_reg    <= res_red_reg;
            out_green_reg  <= res_green_reg;
            out_blue_reg   <= res_blue_reg;
            out_status_reg <= status_reg;
        end
    end

    // key table, registered read; unwritten slots read as black
    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[wr_addr] <= {pixel_in.red, pixel_in.green, pixel_in.blue};
        rd_mem_reg   <= key_mem[rd_addr];
        rd_valid_reg <= key_valid_reg[rd_addr];
    end

    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.out_red   = out_red_reg;
    assign pixel_out.out_green = out_green_reg;
    assign pixel_out.out_blue  = out_blue_reg;
    assign pixel_out.status    = out_status_reg;

    // checks
    `LCG_ASSERT_IMPL(a_div_nonzero, clk, rst_n, div_req.start, div_req.divisor != '0)
    `LCG_ASSERT_NEXT(a_load_shows, clk, rst_n, out_load, pixel_out.valid)
    `LCG_ASSERT_IMPL(a_err_black, clk, rst_n, pixel_out.valid && pixel_out.status != STAT_OK, pixel_out.out_red == '0 && pixel_out.out_green == '0 && pixel_out.out_blue == '0)
    `LCG_ASSERT_IMPL(a_seg_range, clk, rst_n, state_reg == S_RD_SEG, seg_reg < keys_eff)
    `LCG_ASSERT_IMPL(a_div_owner, clk, rst_n, div_rsp.done, state_reg == S_WDIV || state_reg == S_SDIV || state_reg == S_CDIV)
endmodule

FILE: rtl/lcg_div.sv
`timescale 1ns / 1ps
module lcg_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcg_pkg::lcg_div_req_t req,
    output lcg_pkg::lcg_div_rsp_t rsp
);
    import lcg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       trial_sub;
    logic                 fits;

    // one restoring step: bring down the next dividend bit
    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    // control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // datapath
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule
